>>> hdl/assert_macros.svh
// Assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

>>> hdl/qmve_pkg.sv
// Types and constants of the quantized mesh vertex encoder
package qmve_pkg;

    localparam int C_WORD_W = 32;
    localparam int C_CODE_W = 16;
    localparam int C_CFG_IDX_W = 3;
    localparam logic [C_WORD_W-1:0] C_PRE_DEN = 32'h0001_0000;

    localparam logic [C_CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MAX_X = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MIN_Y = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MAX_Y = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MIN_Z = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MODE  = 3'd6;

    typedef struct packed {
        logic signed [C_WORD_W-1:0] coord_x;
        logic signed [C_WORD_W-1:0] coord_y;
        logic signed [C_WORD_W-1:0] coord_z;
        logic                       tile_start;
    } t_vtx_req;

    typedef struct packed {
        logic [C_CODE_W-1:0] u_code;
        logic [C_CODE_W-1:0] v_code;
        logic [C_CODE_W-1:0] h_code;
        logic [C_CODE_W-1:0] vertex_number;
        logic                on_west;
        logic                on_east;
        logic                on_north;
        logic                on_south;
        logic                out_of_range;
    } t_vtx_rsp;

    typedef struct packed {
        logic                early;
        logic                early_max;
        logic                flag;
        logic [C_WORD_W-1:0] num;
        logic [C_WORD_W-1:0] den;
    } t_prep;

endpackage

>>> hdl/quantized_mesh_vertex_encoder_top.sv
// Top level of the quantized mesh vertex encoder
// Takes one vertex request at a time and returns one response with the zigzag-coded
// deltas of the quantized u, v and height, the tile edge flags, the vertex number and
// a range flag. The three axes share one bit-serial divider that gives one quotient
// bit per cycle, W = $clog2(QUANT_MAX+1) quotient bits per axis; the axes are handled
// in turn, and the next request is taken only once the response has been registered.
// An axis that clamps or has an empty extent skips the divider.
// A new request is accepted while the previous response still waits in the output
// register. Configuration writes take effect at once and belong between requests.
module quantized_mesh_vertex_encoder_top
    import qmve_pkg::*;
#(
    parameter int QUANT_MAX = 32767
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [C_WORD_W-1:0]    i_cfg_data,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  t_vtx_req               i_req,
    output logic                   o_rsp_valid,
    input  logic                   i_rsp_ready,
    output t_vtx_rsp               o_rsp
);

    `include "assert_macros.svh"

    localparam int QW = $clog2(QUANT_MAX + 1);
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

    t_state                     r_state;
    t_vtx_req                   r_req;
    t_vtx_rsp                   r_rsp;
    t_vtx_rsp                   w_rsp;
    logic                       r_rsp_valid;
    logic signed [C_WORD_W-1:0] r_min [3];
    logic signed [C_WORD_W-1:0] r_max [3];
    logic                       r_mode;
    logic [1:0]                 r_axis;
    logic                       r_flag;
    logic [QW-1:0]              r_q [3];
    logic [QW-1:0]              r_last_u;
    logic [QW-1:0]              r_last_v;
    logic [QW-1:0]              r_last_h;
    logic [C_CODE_W-1:0]        r_index;
    logic signed [C_WORD_W-1:0] w_coord;
    t_prep                      w_prep;
    logic                       w_div_load;
    logic                       w_div_busy;
    logic [QW-1:0]              w_quot;
    logic [QW-1:0]              w_early_q;
    logic                       w_out_free;

    function automatic logic [C_CODE_W-1:0] zigzag(input logic [C_CODE_W-1:0] now,
                                                   input logic [C_CODE_W-1:0] prev);
        logic [C_CODE_W-1:0] d;
        d = now - prev;
        return {d[C_CODE_W-2:0], 1'b0} ^ {C_CODE_W{d[C_CODE_W-1]}};
    endfunction

    always_comb begin
        case (r_axis)
            AXIS_X:  w_coord = r_req.coord_x;
            AXIS_Y:  w_coord = r_req.coord_y;
            default: w_coord = r_req.coord_z;
        endcase
    end

    qmve_prep #(
        .QUANT_MAX (QUANT_MAX)
    ) u_prep (
        .i_clk       (i_clk),
        .i_coord     (w_coord),
        .i_min       (r_min[r_axis]),
        .i_max       (r_max[r_axis]),
        .i_prescaled (r_mode),
        .o_prep      (w_prep)
    );

    assign w_div_load = (r_state == S_LOAD) && !w_prep.early;

    qmve_div #(
        .QUANT_MAX (QUANT_MAX)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_div_load),
        .i_num   (w_prep.num),
        .i_den   (w_prep.den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign w_early_q  = w_prep.early_max ? QW'(QUANT_MAX) : '0;
    assign w_out_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        w_rsp.u_code        = zigzag(C_CODE_W'(r_q[0]), C_CODE_W'(r_last_u));
        w_rsp.v_code        = zigzag(C_CODE_W'(r_q[1]), C_CODE_W'(r_last_v));
        w_rsp.h_code        = zigzag(C_CODE_W'(r_q[2]), C_CODE_W'(r_last_h));
        w_rsp.vertex_number = r_index;
        w_rsp.on_west       = r_q[0] == '0;
        w_rsp.on_east       = r_q[0] == QW'(QUANT_MAX);
        w_rsp.on_north      = r_q[1] == '0;
        w_rsp.on_south      = r_q[1] == QW'(QUANT_MAX);
        w_rsp.out_of_range  = r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_min       <= '{default: '0};
            r_max       <= '{default: 32'sd1};
            r_mode      <= 1'b0;
            r_axis      <= AXIS_X;
            r_flag      <= 1'b0;
            r_last_u    <= '0;
            r_last_v    <= '0;
            r_last_h    <= '0;
            r_index     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_X: r_min[0] <= i_cfg_data;
                    CFG_MAX_X: r_max[0] <= i_cfg_data;
                    CFG_MIN_Y: r_min[1] <= i_cfg_data;
                    CFG_MAX_Y: r_max[1] <= i_cfg_data;
                    CFG_MIN_Z: r_min[2] <= i_cfg_data;
                    CFG_MAX_Z: r_max[2] <= i_cfg_data;
                    CFG_MODE:  r_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_rsp_valid && i_rsp_ready && r_state != S_OUT) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req  <= i_req;
                        r_axis <= AXIS_X;
                        r_flag <= 1'b0;
                        if (i_req.tile_start) begin
                            r_last_u <= '0;
                            r_last_v <= '0;
                            r_last_h <= '0;
                            r_index  <= '0;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_prep.early) begin
                        r_q[r_axis] <= w_early_q;
                        r_flag      <= r_flag | w_prep.flag;
                        if (r_axis == AXIS_Z) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_PREP;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_q[r_axis] <= w_quot;
                        if (r_axis == AXIS_Z) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_rsp       <= w_rsp;
                        r_rsp_valid <= 1'b1;
                        r_last_u    <= r_q[0];
                        r_last_v    <= r_q[1];
                        r_last_h    <= r_q[2];
                        if (r_index != '1) begin
                            r_index <= r_index + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `ASSERT_CLK(a_rsp_index, (r_state == S_OUT && w_out_free) |=> (o_rsp_valid && o_rsp.vertex_number == $past(r_index)), "response index mismatch")
    `ASSERT_CLK(a_axis_range, (r_state != S_IDLE) |-> (r_axis <= AXIS_Z), "axis select out of range")
    `ASSERT_NEVER(a_west_east, o_rsp_valid && o_rsp.on_west && o_rsp.on_east, "west and east both set")

endmodule

>>> hdl/qmve_prep.sv
// Per-axis range check and divider operand preparation
module qmve_prep
    import qmve_pkg::*;
#(
    parameter int QUANT_MAX = 32767
) (
    input  logic                       i_clk,
    input  logic signed [C_WORD_W-1:0] i_coord,
    input  logic signed [C_WORD_W-1:0] i_min,
    input  logic signed [C_WORD_W-1:0] i_max,
    input  logic                       i_prescaled,
    output t_prep                      o_prep
);

    localparam logic [63:0] PRE_LIM =
        ((64'(QUANT_MAX) + 64'd1) * 64'd65536 + 64'(QUANT_MAX) - 64'd1) / 64'(QUANT_MAX);

    logic signed [C_WORD_W:0] w_ext;
    logic signed [C_WORD_W:0] w_d;
    t_prep                    n_prep;
    t_prep                    r_prep;

    assign w_ext = {i_max[C_WORD_W-1], i_max} - {i_min[C_WORD_W-1], i_min};
    assign w_d   = {i_coord[C_WORD_W-1], i_coord} - {i_min[C_WORD_W-1], i_min};

    always_comb begin
        n_prep.early     = 1'b0;
        n_prep.early_max = 1'b0;
        n_prep.flag      = 1'b0;
        n_prep.num       = w_d[C_WORD_W-1:0];
        n_prep.den       = w_ext[C_WORD_W-1:0];
        if (i_prescaled) begin
            n_prep.num = i_coord;
            n_prep.den = C_PRE_DEN;
            if (i_coord < 0) begin
                n_prep.early = 1'b1;
                n_prep.flag  = 1'b1;
            end else if ({32'd0, i_coord} >= PRE_LIM) begin
                n_prep.early     = 1'b1;
                n_prep.early_max = 1'b1;
                n_prep.flag      = 1'b1;
            end
        end else if (w_ext <= 0 || w_d < 0) begin
            n_prep.early = 1'b1;
            n_prep.flag  = 1'b1;
        end else if (w_d > w_ext) begin
            n_prep.early     = 1'b1;
            n_prep.early_max = 1'b1;
            n_prep.flag      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
    end

    assign o_prep = r_prep;

endmodule

>>> hdl/qmve_div.sv
// Bit-serial restoring divider for floor(num * QUANT_MAX / den)
module qmve_div
    import qmve_pkg::*;
#(
    parameter int QUANT_MAX = 32767
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic [C_WORD_W-1:0]                   i_num,
    input  logic [C_WORD_W-1:0]                   i_den,
    output logic                                  o_busy,
    output logic [$clog2(QUANT_MAX+1)-1:0]        o_quot
);

    `include "assert_macros.svh"

    localparam int QW    = $clog2(QUANT_MAX + 1);
    localparam int CNT_W = $clog2(QW + 1);
    localparam int PW    = C_WORD_W + QW;

    logic [PW-1:0]       w_prod;
    logic [C_WORD_W:0]   w_try;
    logic [C_WORD_W:0]   w_diff;
    logic                w_ge;
    logic [C_WORD_W-1:0] r_rem;
    logic [C_WORD_W-1:0] r_den;
    logic [QW-1:0]       r_sh;
    logic [CNT_W-1:0]    r_cnt;

    assign w_prod = PW'(i_num) * PW'(QUANT_MAX);
    assign w_try  = {r_rem, r_sh[QW-1]};
    assign w_ge   = w_try >= {1'b0, r_den};
    assign w_diff = w_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(QW);
            r_rem <= w_prod[PW-1:QW];
            r_sh  <= w_prod[QW-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[C_WORD_W-1:0] : w_try[C_WORD_W-1:0];
            r_sh  <= {r_sh[QW-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_sh;

    `ASSERT_CLK(a_rem_below_den, (r_cnt != '0) |-> (r_rem < r_den), "remainder reached divisor")
    `ASSERT_NEVER(a_load_while_busy, i_load && o_busy, "divider loaded while busy")

endmodule

>>> tb/qmve_checker.sv
// Response predictor and comparator for the quantized mesh vertex encoder
module qmve_checker
    import qmve_pkg::*;
#(
    parameter int QUANT_MAX = 32767
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [C_WORD_W-1:0]    i_cfg_data,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  t_vtx_req               i_req,
    input  logic                   i_rsp_valid,
    input  logic                   i_rsp_ready,
    input  t_vtx_rsp               i_rsp,
    output int                     o_errors,
    output int                     o_pending
);

    longint      box_lo [3];
    longint      box_hi [3];
    logic        prescaled;
    int          prev_q [3];
    int unsigned vtx_count;
    int          err_count = 0;
    t_vtx_rsp    queued_encodings [$];

    assign o_errors  = err_count;
    assign o_pending = queued_encodings.size();

    function automatic int quantize(input longint c, input longint lo, input longint hi,
                                    input logic pre, output logic clamp);
        longint ext;
        longint d;
        longint q;
        clamp = 1'b0;
        if (pre) begin
            if (c < 0) begin
                clamp = 1'b1;
                return 0;
            end
            q = (c * QUANT_MAX) >>> 16;
            if (q > QUANT_MAX) begin
                clamp = 1'b1;
                return QUANT_MAX;
            end
            return int'(q);
        end
        ext = hi - lo;
        d   = c - lo;
        if (ext <= 0 || d < 0) begin
            clamp = 1'b1;
            return 0;
        end
        if (d > ext) begin
            clamp = 1'b1;
            return QUANT_MAX;
        end
        return int'((d * QUANT_MAX) / ext);
    endfunction

    function automatic logic [C_CODE_W-1:0] zigzag(input int now, input int prev);
        int d;
        int z;
        d = now - prev;
        z = (d >= 0) ? 2 * d : -2 * d - 1;
        return z[C_CODE_W-1:0];
    endfunction

    task automatic report_field(input string field, input logic [C_CODE_W-1:0] want,
                                input logic [C_CODE_W-1:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_vtx_rsp want;
        longint   coord [3];
        int       q [3];
        logic     clamp_bit;
        logic     any_clamp;
        if (!i_rst_n) begin
            box_lo    = '{0, 0, 0};
            box_hi    = '{1, 1, 1};
            prescaled = 1'b0;
            prev_q    = '{0, 0, 0};
            vtx_count = 0;
            queued_encodings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_X: box_lo[0] = longint'($signed(i_cfg_data));
                    CFG_MAX_X: box_hi[0] = longint'($signed(i_cfg_data));
                    CFG_MIN_Y: box_lo[1] = longint'($signed(i_cfg_data));
                    CFG_MAX_Y: box_hi[1] = longint'($signed(i_cfg_data));
                    CFG_MIN_Z: box_lo[2] = longint'($signed(i_cfg_data));
                    CFG_MAX_Z: box_hi[2] = longint'($signed(i_cfg_data));
                    CFG_MODE:  prescaled = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (queued_encodings.size() == 0) begin
                    err_count++;
                    $display("%0t: response with none outstanding, expected nothing, got %h",
                             $time, i_rsp);
                end else begin
                    want = queued_encodings.pop_front();
                    report_field("u_code", want.u_code, i_rsp.u_code);
                    report_field("v_code", want.v_code, i_rsp.v_code);
                    report_field("h_code", want.h_code, i_rsp.h_code);
                    report_field("vertex_number", want.vertex_number, i_rsp.vertex_number);
                    report_field("on_west", C_CODE_W'(want.on_west),
                                 C_CODE_W'(i_rsp.on_west));
                    report_field("on_east", C_CODE_W'(want.on_east),
                                 C_CODE_W'(i_rsp.on_east));
                    report_field("on_north", C_CODE_W'(want.on_north),
                                 C_CODE_W'(i_rsp.on_north));
                    report_field("on_south", C_CODE_W'(want.on_south),
                                 C_CODE_W'(i_rsp.on_south));
                    report_field("out_of_range", C_CODE_W'(want.out_of_range),
                                 C_CODE_W'(i_rsp.out_of_range));
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req.tile_start) begin
                    prev_q    = '{0, 0, 0};
                    vtx_count = 0;
                end
                coord[0]  = longint'($signed(i_req.coord_x));
                coord[1]  = longint'($signed(i_req.coord_y));
                coord[2]  = longint'($signed(i_req.coord_z));
                any_clamp = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    q[k] = quantize(coord[k], box_lo[k], box_hi[k], prescaled, clamp_bit);
                    any_clamp |= clamp_bit;
                end
                want.u_code        = zigzag(q[0], prev_q[0]);
                want.v_code        = zigzag(q[1], prev_q[1]);
                want.h_code        = zigzag(q[2], prev_q[2]);
                want.vertex_number = vtx_count[C_CODE_W-1:0];
                want.on_west       = (q[0] == 0);
                want.on_east       = (q[0] == QUANT_MAX);
                want.on_north      = (q[1] == 0);
                want.on_south      = (q[1] == QUANT_MAX);
                want.out_of_range  = any_clamp;
                prev_q = q;
                if (vtx_count < 32'hFFFF)
                    vtx_count++;
                queued_encodings = {queued_encodings, want};
            end
        end
    end

endmodule

>>> tb/tb_quantized_mesh_vertex_encoder_top.sv
// Stimulus and verdict for the quantized mesh vertex encoder testbench
module tb_quantized_mesh_vertex_encoder_top;
    import qmve_pkg::*;

    localparam int QUANT_MAX      = 32767;
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 135;
    localparam logic [C_CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [C_CFG_IDX_W-1:0] MIN_IDX [3] = '{CFG_MIN_X, CFG_MIN_Y, CFG_MIN_Z};
    localparam logic [C_CFG_IDX_W-1:0] MAX_IDX [3] = '{CFG_MAX_X, CFG_MAX_Y, CFG_MAX_Z};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [C_CFG_IDX_W-1:0] cfg_idx = '0;
    logic [C_WORD_W-1:0]    cfg_data = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    t_vtx_req               req = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    t_vtx_rsp               rsp;
    int                     errors;
    int                     pending;
    int                     send_idle_pct = 0;
    int                     rsp_stall_pct = 0;
    int                     quiet_cycles = 0;
    longint                 cur_lo [3];
    longint                 cur_hi [3];
    logic                   cur_pre = 1'b0;

    always #10 clk = ~clk;

    quantized_mesh_vertex_encoder_top #(
        .QUANT_MAX(QUANT_MAX)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp      (rsp)
    );

    qmve_checker #(
        .QUANT_MAX(QUANT_MAX)
    ) encode_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req_valid(req_valid),
        .i_req_ready(req_ready),
        .i_req      (req),
        .i_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .i_rsp      (rsp),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always @(negedge clk) begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_vertex(input t_vtx_req vtx);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req       = vtx;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic send_xyz(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic start);
        t_vtx_req vtx;
        vtx.coord_x    = x;
        vtx.coord_y    = y;
        vtx.coord_z    = z;
        vtx.tile_start = start;
        send_vertex(vtx);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input logic [C_WORD_W-1:0] data);
        drain();
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic set_box(input int axis, input longint lo, input longint hi);
        cur_lo[axis] = lo;
        cur_hi[axis] = hi;
        write_reg(MIN_IDX[axis], lo[31:0]);
        write_reg(MAX_IDX[axis], hi[31:0]);
    endtask

    task automatic set_mode(input logic pre);
        cur_pre = pre;
        write_reg(CFG_MODE, {31'd0, pre});
    endtask

    function automatic logic signed [31:0] rand_word();
        return $urandom;
    endfunction

    task automatic random_box(input int axis);
        longint a;
        longint b;
        a = longint'(rand_word());
        b = longint'(rand_word());
        case ($urandom_range(9))
            0: set_box(axis, -64'sd2147483648, 64'sd2147483647);
            1: set_box(axis, a, a);
            2: set_box(axis, (a > b) ? a : b, (a > b) ? b : a);
            3, 4, 5: set_box(axis, a >>> 1, (a >>> 1) + $urandom_range(1, 300));
            default: set_box(axis, (a < b) ? a : b, (a < b) ? b : a);
        endcase
    endtask

    function automatic logic [31:0] pick_coord(input int axis);
        int     r;
        longint ext;
        longint off;
        longint val;
        r = $urandom_range(99);
        if (cur_pre) begin
            if (r < 70)
                return $urandom_range(65540);
            if (r < 80) begin
                case ($urandom_range(5))
                    0: return 32'd0;
                    1: return 32'd65536;
                    2: return 32'd65538;
                    3: return 32'd65539;
                    4: return 32'hFFFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            return $urandom;
        end
        ext = cur_hi[axis] - cur_lo[axis];
        if (r < 75 && ext > 0) begin
            off = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (ext + 1);
            val = cur_lo[axis] + off;
            return val[31:0];
        end
        if (r < 88) begin
            case ($urandom_range(3))
                0: val = cur_lo[axis];
                1: val = cur_hi[axis];
                2: val = cur_lo[axis] - 1;
                default: val = cur_hi[axis] + 1;
            endcase
            return val[31:0];
        end
        return $urandom;
    endfunction

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
    endtask

    initial begin
        cur_lo = '{0, 0, 0};
        cur_hi = '{1, 1, 1};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset box is 0..1 on every axis
        send_xyz(32'd0, 32'd0, 32'd0, 1'b1);
        send_xyz(32'd1, 32'd1, 32'd1, 1'b0);
        send_xyz(32'hFFFF_FFFF, 32'd2, 32'd0, 1'b0);
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0);

        set_box(0, -64'sd2147483648, 64'sd2147483647);
        set_box(1, -1000, 1000);
        set_box(2, 5, 5);
        send_xyz(32'h8000_0000, -1000, 32'd5, 1'b0);
        send_xyz(32'h7FFF_FFFF, 32'd1000, 32'd0, 1'b0);
        send_xyz(32'd0, 32'd0, -5, 1'b0);
        send_xyz(32'd1, -999, 32'd6, 1'b0);

        set_box(2, 10, -10);
        send_xyz(32'hFFFF_FFFF, 32'd999, 32'd10, 1'b1);
        send_xyz(32'h4000_0000, 32'd1001, 32'd0, 1'b0);

        set_mode(1'b1);
        send_xyz(32'd0, 32'd65536, 32'd65538, 1'b0);
        send_xyz(32'hFFFF_FFFF, 32'd65539, 32'h7FFF_FFFF, 1'b0);
        send_xyz(32'h8000_0000, 32'd1, 32'd32768, 1'b1);
        send_xyz(32'd65535, 32'd2, 32'd3, 1'b0);
        send_xyz(32'd65537, 32'd0, 32'h0001_FFFF, 1'b0);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        send_xyz(32'd100, 32'd200, 32'd300, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(62, 0);
                2: set_idling(0, 62);
                default: set_idling(11, 11);
            endcase
            for (int a = 0; a < 3; a++) begin
                if (p == 0)
                    set_box(a, -64'sd2147483648, 64'sd2147483647);
                else
                    random_box(a);
            end
            set_mode(p == 2 || p == 5 || p == 7);
            if (p == 1)
                write_reg(CFG_SPARE, $urandom);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == PHASE_ITEMS / 2)
                    drain();
                send_xyz(pick_coord(0), pick_coord(1), pick_coord(2), $urandom_range(99) < 4);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
